// File: rtl/button_gesture_detector_defines.svh
// Assertion macros shared by the button gesture detector checker.
// No dependencies; included by bgd_checker.sv.
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// Property checked every clock, muted while reset is high.
`define BGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked every clock, reset included.
`define BGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bgd_pkg.sv
// Shared types and constants for the button gesture detector.
// No dependencies; imported by the top level, bgd_update, bgd_outq and the bench.
package bgd_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_HOLD_TIME    = 2'd0;
  localparam logic [1:0] REG_TAP_MAX_DOWN = 2'd1;
  localparam logic [1:0] REG_TAP_MAX_GAP  = 2'd2;

  localparam logic [31:0] HOLD_TIME_RST    = 32'd500000;
  localparam logic [31:0] TAP_MAX_DOWN_RST = 32'd250000;
  localparam logic [31:0] TAP_MAX_GAP_RST  = 32'd300000;

  localparam int CH_W       = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Result item; declared MSB first so that out_channel lands in the low bits.
  typedef struct packed {
    logic            double_tap_event;
    logic            single_tap_event;
    logic            hold_event;
    logic            release_event;
    logic            press_event;
    logic            cur_level;
    logic [CH_W-1:0] out_channel;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // Gesture thresholds as seen by the update logic
  typedef struct packed {
    logic [31:0] hold_min_us;
    logic [31:0] tap_max_down_us;
    logic [31:0] tap_max_gap_us;
  } cfg_t;

endpackage

// File: rtl/button_gesture_detector.sv
// Button gesture detector: press, release, hold, single and double tap events.
// Top level; depends on bgd_pkg, bgd_ram, bgd_update and bgd_outq.
//
// Usage:
//  - in_* stream: one transfer per button sample (channel, level, timestamp).
//  - out_* stream: exactly one result transfer per input transfer, in order,
//    carrying the channel, the level and the event flags.
//  - cfg_* channel: writes the three thresholds; cfg_ready is high outside reset.
//    Write only while no input transfer is still waiting for its result.
// The memory read is issued at the accepting edge, where the sample enters
// stage 1; the update is then pushed into the result queue, and out_tvalid
// is high whenever that queue holds a result.
// Throughput: one transfer per cycle while in_tready is high; the memory has
// one read and one write port; a next-cycle same-channel item is forwarded.
// Stall: when out_tready is low, results pile up in a three-entry queue;
// in_tready drops once the queue plus the update stage hold three items.
// Reset: synchronous; thresholds return to their defaults and every channel
// reads as released with no pending tap (per-entry valid bits), with no
// clearing pass, so inputs are taken from the first cycle after reset.
module button_gesture_detector #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // tdata: channel[2:0], pressed_level[3], time_us[35:4], zero pad[39:36]
  input  logic [bgd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: out_channel[2:0], cur_level[3], press_event[4], release_event[5],
  //        hold_event[6], single_tap_event[7], double_tap_event[8], zero pad
  output logic [bgd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready
);
  import bgd_pkg::*;

  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // memory word: {release_time, press_time, tap_pending, held_flag, last_level}
  localparam int ENTRY_W = 3 + 2 * TIME_BITS;

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_min_us     <= HOLD_TIME_RST;
      cfg.tap_max_down_us <= TAP_MAX_DOWN_RST;
      cfg.tap_max_gap_us  <= TAP_MAX_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_TIME:    cfg.hold_min_us     <= cfg_data;
        REG_TAP_MAX_DOWN: cfg.tap_max_down_us <= cfg_data;
        REG_TAP_MAX_GAP:  cfg.tap_max_gap_us  <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg_ready = !rst;

  // input unpack
  logic [CH_W-1:0]      in_channel;
  logic                 in_level;
  logic [31:0]          in_time;
  logic                 accept;

  assign in_channel = in_tdata[CH_W-1:0];
  assign in_level   = in_tdata[CH_W];
  assign in_time    = in_tdata[CH_W+32:CH_W+1];
  assign accept     = in_tvalid && in_tready;

  // stage 1: accepted sample meets the memory read data; update runs here
  logic                 s1_valid;
  logic                 s1_in_range;
  logic [CH_W-1:0]      s1_channel;
  logic [AW-1:0]        s1_addr;
  logic                 s1_level;
  logic [TIME_BITS-1:0] s1_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range <= (32'(in_channel) < 32'(CHANNELS));
      s1_channel  <= in_channel;
      s1_addr     <= AW'(in_channel);
      s1_level    <= in_level;
      s1_now      <= TIME_BITS'(in_time);
    end
  end

  // channel store
  logic               we;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;

  bgd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (wdata),
    .raddr (AW'(in_channel)),
    .rdata (rdata)
  );

  // valid bits stand in for clearing the store at reset
  logic [CHANNELS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[s1_addr] <= 1'b1;
    end
  end

  // forward the word written last cycle; the memory read missed it
  logic               fw_valid;
  logic [AW-1:0]      fw_addr;
  logic [ENTRY_W-1:0] fw_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fw_addr  <= s1_addr;
      fw_entry <= wdata;
    end
  end

  logic [ENTRY_W-1:0] entry;

  always_comb begin
    if (fw_valid && (fw_addr == s1_addr)) begin
      entry = fw_entry;
    end else if (s1_in_range && vld[s1_addr]) begin
      entry = rdata;
    end else begin
      entry = '0;
    end
  end

  logic                 last_level_next;
  logic                 held_flag_next;
  logic                 tap_pending_next;
  logic [TIME_BITS-1:0] press_time_next;
  logic [TIME_BITS-1:0] release_time_next;
  result_t              result;

  bgd_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .in_range          (s1_in_range),
    .channel           (s1_channel),
    .lvl               (s1_level),
    .now               (s1_now),
    .cfg               (cfg),
    .last_level        (entry[0]),
    .held_flag         (entry[1]),
    .tap_pending       (entry[2]),
    .press_time        (entry[TIME_BITS+2:3]),
    .release_time      (entry[2*TIME_BITS+2:TIME_BITS+3]),
    .last_level_next   (last_level_next),
    .held_flag_next    (held_flag_next),
    .tap_pending_next  (tap_pending_next),
    .press_time_next   (press_time_next),
    .release_time_next (release_time_next),
    .result            (result)
  );

  assign we    = s1_valid && s1_in_range;
  assign wdata = {release_time_next, press_time_next,
                  tap_pending_next, held_flag_next, last_level_next};

  // result queue
  result_t    head_data;
  logic [1:0] q_count;
  logic       pop;

  assign pop = out_tvalid && out_tready;

  bgd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (result),
    .pop       (pop),
    .not_empty (out_tvalid),
    .head_data (head_data),
    .count     (q_count)
  );

  // room for the item in stage 1 plus one more; closed during reset
  assign in_tready = !rst && (({1'b0, q_count} + {2'b0, s1_valid}) <= 3'd2);
  assign out_tdata = {(OUT_DATA_W - RESULT_W)'(0), head_data};

endmodule

// File: rtl/bgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bgd_update.sv
// Per-channel gesture update: edge detection, timers and tap bookkeeping.
// Depends on bgd_pkg.
module bgd_update #(
  parameter int TIME_BITS = 32
) (
  input  logic                    in_range,
  input  logic [bgd_pkg::CH_W-1:0] channel,
  input  logic                    lvl,
  input  logic [TIME_BITS-1:0]    now,
  input  bgd_pkg::cfg_t           cfg,
  input  logic                    last_level,
  input  logic                    held_flag,
  input  logic                    tap_pending,
  input  logic [TIME_BITS-1:0]    press_time,
  input  logic [TIME_BITS-1:0]    release_time,
  output logic                    last_level_next,
  output logic                    held_flag_next,
  output logic                    tap_pending_next,
  output logic [TIME_BITS-1:0]    press_time_next,
  output logic [TIME_BITS-1:0]    release_time_next,
  output bgd_pkg::result_t        result
);
  import bgd_pkg::*;

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [TIME_BITS-1:0] el_press;
  logic [TIME_BITS-1:0] el_rel;
  logic                 ge_hold;
  logic                 ge_down;
  logic                 ge_gap;

  // elapsed times wrap modulo 2^TIME_BITS
  assign el_press = now - press_time;
  assign el_rel   = now - release_time;
  assign ge_hold  = CMP_W'(el_press) >= CMP_W'(cfg.hold_min_us);
  assign ge_down  = CMP_W'(el_press) >= CMP_W'(cfg.tap_max_down_us);
  assign ge_gap   = CMP_W'(el_rel)   >= CMP_W'(cfg.tap_max_gap_us);

  always_comb begin
    last_level_next   = last_level;
    held_flag_next    = held_flag;
    tap_pending_next  = tap_pending;
    press_time_next   = press_time;
    release_time_next = release_time;
    result            = '0;
    result.out_channel = channel;
    result.cur_level   = lvl;
    if (in_range) begin
      if (lvl != last_level) begin
        last_level_next = lvl;
        if (lvl) begin
          press_time_next    = now;
          result.press_event = 1'b1;
          if (ge_gap) begin
            tap_pending_next = 1'b0;
          end
        end else begin
          release_time_next    = now;
          held_flag_next       = 1'b0;
          result.release_event = 1'b1;
          if (ge_down) begin
            tap_pending_next = 1'b0;   // too long to be a tap
          end else if (tap_pending) begin
            result.double_tap_event = 1'b1;
            tap_pending_next        = 1'b0;
          end else begin
            tap_pending_next = 1'b1;
          end
        end
      end else if (lvl) begin
        if (!held_flag && ge_hold) begin
          held_flag_next    = 1'b1;
          result.hold_event = 1'b1;
        end
      end else begin
        if (tap_pending && ge_gap) begin
          result.single_tap_event = 1'b1;
          tap_pending_next        = 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/bgd_outq.sv
// Three-entry result queue that decouples the update stage from the receiver.
// Depends on bgd_pkg.
module bgd_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bgd_pkg::result_t push_data,
  input  logic             pop,
  output logic             not_empty,
  output bgd_pkg::result_t head_data,
  output logic [1:0]       count
);
  import bgd_pkg::*;

  localparam logic [1:0] LAST_SLOT = 2'd2;

  result_t    q [3];
  logic [1:0] head;
  logic [1:0] head_next;
  logic [1:0] count_next;
  logic [2:0] tail_sum;
  logic [1:0] tail;

  assign tail_sum  = {1'b0, head} + {1'b0, count};
  assign tail      = (tail_sum > 3'd2) ? 2'(tail_sum - 3'd3) : tail_sum[1:0];
  assign head_next = (head == LAST_SLOT) ? 2'd0 : head + 2'd1;
  assign count_next = count + {1'b0, push} - {1'b0, pop};
  assign not_empty  = (count != 2'd0);
  assign head_data  = q[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      count <= 2'd0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_data;
    end
  end

endmodule

// File: rtl/bgd_checker.sv
// Port-level checks for the button gesture detector, bound to its top level.
// Depends on button_gesture_detector_defines.svh.
module bgd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);
`include "button_gesture_detector_defines.svh"

  // a stalled result stays put
  `BGD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // nothing is offered right after reset
  `BGD_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_tvalid, "result offered after reset")

  // press, release, hold and single tap exclude each other; double tap comes with release
  `BGD_ASSERT(a_evt_excl, out_tvalid |-> $onehot0(out_tdata[7:4]) && (!out_tdata[8] || out_tdata[5]), "conflicting events")

  // events agree with the reported level
  `BGD_ASSERT(a_evt_level, out_tvalid |-> ((!out_tdata[4] && !out_tdata[6]) || out_tdata[3]) && ((!out_tdata[5] && !out_tdata[7]) || !out_tdata[3]), "event against level")

  // input is only held off while results are backed up
  `BGD_ASSERT(a_in_stall, in_tvalid && !in_tready |-> out_tvalid, "input refused with no result waiting")

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// File: test/tb_button_gesture_detector.sv
// Self-checking bench for button_gesture_detector: directed gestures, threshold extremes
// and random gesture streams under random stalls on both stream sides.
// Depends on bgd_pkg and the button_gesture_detector RTL.
module tb_button_gesture_detector;
  import bgd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [1:0]            cfg_index;
  logic [31:0]           cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  // Percent of cycles in which each side holds off
  int send_idle = 0;
  int recv_idle = 0;
  int mismatch_count = 0;

  // Bench copy of the thresholds and of the per-channel gesture state
  logic [31:0] thr_hold;
  logic [31:0] thr_tap_down;
  logic [31:0] thr_tap_gap;
  logic        btn_level     [8];
  logic        btn_held      [8];
  logic        btn_tap_armed [8];
  logic [31:0] btn_press_at  [8];
  logic [31:0] btn_release_at[8];

  // Predicted result of every accepted sample, oldest first
  result_t expected_results[$];

  always #4 clk = ~clk;

  button_gesture_detector i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  // Gesture update for one sample; elapsed times wrap modulo 2^32.
  function automatic result_t predict_gesture(logic [2:0] ch, logic lvl, logic [31:0] now);
    result_t     r;
    logic [31:0] since_press;
    logic [31:0] since_release;
    r             = '0;
    r.out_channel = ch;
    r.cur_level   = lvl;
    since_press   = now - btn_press_at[ch];
    since_release = now - btn_release_at[ch];
    if (lvl != btn_level[ch]) begin
      btn_level[ch] = lvl;
      if (lvl) begin
        btn_press_at[ch] = now;
        r.press_event    = 1'b1;
        // gap too long: the earlier tap no longer pairs with this one
        if (since_release >= thr_tap_gap) btn_tap_armed[ch] = 1'b0;
      end else begin
        btn_release_at[ch] = now;
        btn_held[ch]       = 1'b0;
        r.release_event    = 1'b1;
        if (since_press >= thr_tap_down) begin
          btn_tap_armed[ch] = 1'b0;
        end else if (btn_tap_armed[ch]) begin
          r.double_tap_event = 1'b1;
          btn_tap_armed[ch]  = 1'b0;
        end else begin
          btn_tap_armed[ch] = 1'b1;
        end
      end
    end else if (lvl) begin
      if (!btn_held[ch] && since_press >= thr_hold) begin
        btn_held[ch] = 1'b1;
        r.hold_event = 1'b1;
      end
    end else if (btn_tap_armed[ch] && since_release >= thr_tap_gap) begin
      r.single_tap_event = 1'b1;
      btn_tap_armed[ch]  = 1'b0;
    end
    return r;
  endfunction

  // Offset from an event time: on, just around or below a threshold, or fully random
  function automatic logic [31:0] near_threshold(logic [31:0] thr);
    case ($urandom_range(3))
      0:       return thr - $urandom_range(3);
      1:       return thr + $urandom_range(3);
      2:       return $urandom_range(thr, 0);
      default: return $urandom;
    endcase
  endfunction

  // One input transfer; the prediction is taken at the accepting edge.
  task automatic send_sample(logic [2:0] ch, logic lvl, logic [31:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {4'b0, t, lvl, ch};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_gesture(ch, lvl, t));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HOLD_TIME:    thr_hold     = val;
      REG_TAP_MAX_DOWN: thr_tap_down = val;
      REG_TAP_MAX_GAP:  thr_tap_gap  = val;
      default: ;
    endcase
  endtask

  // Thresholds change only with the block drained
  task automatic set_thresholds(logic [31:0] hold, logic [31:0] down, logic [31:0] gap);
    drain_results();
    write_threshold(REG_HOLD_TIME, hold);
    write_threshold(REG_TAP_MAX_DOWN, down);
    write_threshold(REG_TAP_MAX_GAP, gap);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reset thresholds: double tap, hold once, single tap timeout, timestamp wrap,
  // tap cancelled by a long gap.
  task automatic test_reset_defaults();
    send_sample(3'd0, 1'b1, 32'd1000);
    send_sample(3'd0, 1'b0, 32'd101000);
    send_sample(3'd0, 1'b1, 32'd201000);
    send_sample(3'd0, 1'b0, 32'd250000);
    send_sample(3'd1, 1'b1, 32'd5000);
    send_sample(3'd1, 1'b1, 32'd504999);   // one short of the hold time
    send_sample(3'd1, 1'b1, 32'd505000);
    send_sample(3'd1, 1'b1, 32'd900000);   // hold fires once per press
    send_sample(3'd1, 1'b0, 32'd905000);
    send_sample(3'd2, 1'b1, 32'd0);
    send_sample(3'd2, 1'b0, 32'd249999);
    send_sample(3'd2, 1'b0, 32'd549998);
    send_sample(3'd2, 1'b0, 32'd549999);
    send_sample(3'd3, 1'b1, 32'hFFFF_FF00);
    send_sample(3'd3, 1'b1, 32'h0007_A020); // hold across the wrap
    send_sample(3'd3, 1'b0, 32'h0003_D000);
    send_sample(3'd4, 1'b1, 32'd10);
    send_sample(3'd4, 1'b0, 32'd20);
    send_sample(3'd4, 1'b1, 32'd300020);   // gap reaches the limit exactly
    send_sample(3'd4, 1'b0, 32'd300030);
    send_sample(3'd7, 1'b0, 32'hFFFF_FFFF);
  endtask

  // All-zero thresholds fire at once; all-ones need an elapsed time of 2^32-1.
  task automatic test_threshold_extremes();
    set_thresholds(32'd0, 32'd0, 32'd0);
    send_sample(3'd5, 1'b1, 32'd10);
    send_sample(3'd5, 1'b1, 32'd10);
    send_sample(3'd5, 1'b0, 32'd10);
    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(3'd6, 1'b1, 32'd100);
    send_sample(3'd6, 1'b0, 32'd101);
    send_sample(3'd6, 1'b0, 32'd100);
    send_sample(3'd6, 1'b1, 32'd300);
    send_sample(3'd6, 1'b0, 32'd300);
    send_sample(3'd6, 1'b1, 32'd400);
    send_sample(3'd6, 1'b0, 32'd400);
    send_sample(3'd5, 1'b1, 32'd500);
    send_sample(3'd5, 1'b1, 32'd499);
  endtask

  // Mostly well-formed gestures timed around the live thresholds, some noise.
  task automatic test_random_gestures(int n_items);
    logic [2:0]  ch;
    logic        lvl;
    logic [31:0] t;
    for (int i = 0; i < n_items; i++) begin
      ch = 3'($urandom_range(7));
      if ($urandom_range(99) < 15) begin
        lvl = 1'($urandom_range(1));
        t   = $urandom;
      end else begin
        lvl = $urandom_range(1) ? ~btn_level[ch] : btn_level[ch];
        if (lvl != btn_level[ch]) begin
          if (lvl) t = btn_release_at[ch] + near_threshold(thr_tap_gap);
          else     t = btn_press_at[ch] +
                       near_threshold($urandom_range(1) ? thr_tap_down : thr_hold);
        end else if (lvl) begin
          t = btn_press_at[ch] + near_threshold(thr_hold);
        end else begin
          t = btn_release_at[ch] + near_threshold(thr_tap_gap);
        end
      end
      send_sample(ch, lvl, t);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random back-pressure, driven on the falling edge
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle);
  end

  // Result checker: each output transfer against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[RESULT_W-1:0]);
      if (expected_results.size() == 0) begin
        $error("result transfer with no sample outstanding: %0h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
        check_field("cur_level", 32'(want.cur_level), 32'(got.cur_level));
        check_field("press_event", 32'(want.press_event), 32'(got.press_event));
        check_field("release_event", 32'(want.release_event), 32'(got.release_event));
        check_field("hold_event", 32'(want.hold_event), 32'(got.hold_event));
        check_field("single_tap_event", 32'(want.single_tap_event),
                    32'(got.single_tap_event));
        check_field("double_tap_event", 32'(want.double_tap_event),
                    32'(got.double_tap_event));
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_HOLD_TIME;
    cfg_data     = '0;
    thr_hold     = HOLD_TIME_RST;
    thr_tap_down = TAP_MAX_DOWN_RST;
    thr_tap_gap  = TAP_MAX_GAP_RST;
    for (int c = 0; c < 8; c++) begin
      btn_level[c]      = 1'b0;
      btn_held[c]       = 1'b0;
      btn_tap_armed[c]  = 1'b0;
      btn_press_at[c]   = '0;
      btn_release_at[c] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender idles more rarely than the receiver
    send_idle = 38;
    recv_idle = 59;
    test_reset_defaults();
    test_threshold_extremes();
    set_thresholds($urandom_range(100, 1000), $urandom_range(10, 200), $urandom_range(10, 300));
    test_random_gestures(125);
    set_thresholds($urandom_range(20, 200), $urandom_range(20, 200), $urandom_range(20, 200));
    test_random_gestures(125);

    // roles swapped
    send_idle = 59;
    recv_idle = 38;
    set_thresholds(HOLD_TIME_RST, TAP_MAX_DOWN_RST, TAP_MAX_GAP_RST);
    test_random_gestures(125);
    set_thresholds($urandom, $urandom, $urandom);
    test_random_gestures(125);

    // full rate on both sides
    send_idle = 0;
    recv_idle = 0;
    set_thresholds(32'hFFFF_FFFF, $urandom_range(1, 100), 32'd0);
    test_random_gestures(125);
    set_thresholds($urandom_range(100, 1000), $urandom_range(10, 200), $urandom_range(10, 300));
    test_random_gestures(125);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #(8 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule
